[rtl/rbu_pkg.sv]
`timescale 1ns / 1ps

package rbu_pkg;

  // Pixel geometry
  localparam int NumChannels = 4;
  localparam int ChanW       = 8;

  // Configuration port
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 2;

  localparam logic [CfgIndexW-1:0] RegOwnFactor = 2'd0;
  localparam logic [CfgIndexW-1:0] RegIncFactor = 2'd1;
  localparam logic [CfgIndexW-1:0] RegCombine   = 2'd2;

  // Factor mode codes (unused code means one)
  localparam logic [1:0] FactorOne      = 2'd0;
  localparam logic [1:0] FactorOwnAlpha = 2'd1;
  localparam logic [1:0] FactorInvAlpha = 2'd2;

  // Combine mode codes (unused code means keep)
  localparam logic [1:0] CombineKeep     = 2'd0;
  localparam logic [1:0] CombineModulate = 2'd1;
  localparam logic [1:0] CombineAdd      = 2'd2;

  // Fixed-point constants: values are integers over 255
  localparam logic [ChanW-1:0] FullScale  = 8'd255;
  localparam logic [16:0]      SatLimit   = 17'd65025;     // 255^2
  localparam logic [23:0]      ModDivisor = 24'd16581375;  // 255^3
  localparam logic [16:0]      ModRecip   = 17'd66310;     // floor(2^40 / 255^3)
  localparam logic [8:0]       AddRecip   = 9'd257;        // 2^16 / 255, rounded down

  // Per-stage load enables of the lane pipeline and the output register
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } rbu_load_t;

  // Scale factor over 255 for a side
  function automatic logic [ChanW-1:0] pick_factor(input logic [1:0] mode,
                                                    input logic [ChanW-1:0] alpha);
    logic [ChanW-1:0] f;
    case (mode)
      FactorOwnAlpha: f = alpha;
      FactorInvAlpha: f = FullScale - alpha;
      default:        f = FullScale;
    endcase
    return f;
  endfunction

endpackage

[rtl/rbu_if.sv]
`timescale 1ns / 1ps

// Input channel: own and incoming pixel
interface rbu_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] own_red;
  logic [7:0] own_green;
  logic [7:0] own_blue;
  logic [7:0] own_alpha;
  logic [7:0] incoming_red;
  logic [7:0] incoming_green;
  logic [7:0] incoming_blue;
  logic [7:0] incoming_alpha;

  modport source (
    output valid, own_red, own_green, own_blue, own_alpha,
           incoming_red, incoming_green, incoming_blue, incoming_alpha,
    input  ready
  );
  modport sink (
    input  valid, own_red, own_green, own_blue, own_alpha,
           incoming_red, incoming_green, incoming_blue, incoming_alpha,
    output ready
  );
endinterface

// Output channel: blended pixel
interface rbu_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

[rtl/rbu_ctrl.sv]
`timescale 1ns / 1ps

module rbu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output rbu_pkg::rbu_load_t load
);

  // valid[0..2] for the lane stages, valid[3] for the output register
  logic [3:0] valid;

  // Load a stage when it is empty or its content moves on
  always_comb begin
    load.s4 = !valid[3] || out_ready;
    load.s3 = !valid[2] || load.s4;
    load.s2 = !valid[1] || load.s3;
    load.s1 = !valid[0] || load.s2;
  end

  assign in_ready  = load.s1;
  assign out_valid = valid[3];

  // Advance the valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load.s1) valid[0] <= in_valid;
      if (load.s2) valid[1] <= valid[0];
      if (load.s3) valid[2] <= valid[1];
      if (load.s4) valid[3] <= valid[2];
    end
  end

endmodule

[rtl/rbu_lane.sv]
`timescale 1ns / 1ps

module rbu_lane (
  input  logic                      clk,
  input  logic [rbu_pkg::ChanW-1:0] own_chan,
  input  logic [rbu_pkg::ChanW-1:0] inc_chan,
  input  logic [rbu_pkg::ChanW-1:0] own_factor,
  input  logic [rbu_pkg::ChanW-1:0] inc_factor,
  input  logic [1:0]                combine_mode,
  input  rbu_pkg::rbu_load_t        load,
  output logic [rbu_pkg::ChanW-1:0] result
);

  // Stage 1: scaled values over 255^2
  logic [15:0]               s_own_1;
  logic [15:0]               s_inc_1;
  logic [rbu_pkg::ChanW-1:0] own_1;

  // Stage 2: product over 255^4 and sum over 255^2
  logic [31:0]               prod_2;
  logic [16:0]               sum_2;
  logic [rbu_pkg::ChanW-1:0] own_2;

  // Stage 3: quotient estimates, never above the true quotient by construction
  logic [8:0]                mod_est_3;
  logic [31:0]               prod_3;
  logic [rbu_pkg::ChanW-1:0] add_est_3;
  logic [15:0]               sum_3;
  logic                      sat_3;
  logic [rbu_pkg::ChanW-1:0] own_3;

  logic [32:0]               mod_est_full;
  logic [25:0]               add_est_full;
  logic [32:0]               mod_back;
  logic [32:0]               mod_rem;
  logic [8:0]                mod_q;
  logic [15:0]               add_back;
  logic [15:0]               add_rem;
  logic [rbu_pkg::ChanW-1:0] add_q;
  logic [rbu_pkg::ChanW-1:0] add_res;

  // Scale both sides
  always_ff @(posedge clk) begin
    if (load.s1) begin
      s_own_1 <= 16'(own_chan) * 16'(own_factor);
      s_inc_1 <= 16'(inc_chan) * 16'(inc_factor);
      own_1   <= own_chan;
    end
  end

  // Modulate and add
  always_ff @(posedge clk) begin
    if (load.s2) begin
      prod_2 <= 32'(s_own_1) * 32'(s_inc_1);
      sum_2  <= 17'(s_own_1) + 17'(s_inc_1);
      own_2  <= own_1;
    end
  end

  // Estimate the quotients by reciprocal multiplication
  assign mod_est_full = 33'(prod_2[31:16]) * 33'(rbu_pkg::ModRecip);
  assign add_est_full = 26'(sum_2) * 26'(rbu_pkg::AddRecip);

  always_ff @(posedge clk) begin
    if (load.s3) begin
      mod_est_3 <= mod_est_full[32:24];
      prod_3    <= prod_2;
      add_est_3 <= add_est_full[23:16];
      sum_3     <= sum_2[15:0];
      sat_3     <= (sum_2 >= rbu_pkg::SatLimit);
      own_3     <= own_2;
    end
  end

  // Correct each estimate by at most one
  always_comb begin
    mod_back = 33'(mod_est_3) * 33'(rbu_pkg::ModDivisor);
    mod_rem  = 33'(prod_3) - mod_back;
    mod_q    = (mod_rem >= 33'(rbu_pkg::ModDivisor)) ? mod_est_3 + 9'd1 : mod_est_3;

    add_back = 16'(add_est_3) * 16'(rbu_pkg::FullScale);
    add_rem  = sum_3 - add_back;
    add_q    = (add_rem >= 16'(rbu_pkg::FullScale)) ? add_est_3 + 8'd1 : add_est_3;
    add_res  = sat_3 ? rbu_pkg::FullScale : add_q;
  end

  // Select by combine mode
  always_comb begin
    case (combine_mode)
      rbu_pkg::CombineModulate: result = mod_q[7:0];
      rbu_pkg::CombineAdd:      result = add_res;
      default:                  result = own_3;
    endcase
  end

endmodule

[rtl/rbu_merge.sv]
`timescale 1ns / 1ps

module rbu_merge (
  input  logic                                                clk,
  input  rbu_pkg::rbu_load_t                                  load,
  input  logic [rbu_pkg::NumChannels-1:0][rbu_pkg::ChanW-1:0] lane_result,
  output logic [rbu_pkg::NumChannels-1:0][rbu_pkg::ChanW-1:0] merged
);

  // Gather the lanes into one output pixel; hold while stalled
  always_ff @(posedge clk) begin
    if (load.s4) begin
      merged <= lane_result;
    end
  end

endmodule

[rtl/rgba_blend_unit.sv]
`timescale 1ns / 1ps

// RGBA8 pixel blender. One pixel pair is taken every cycle unless stalled, and one blended
// pixel leaves when the result side is ready: four channel lanes each run three pipeline
// stages (factor scaling, modulate/add multiply, reciprocal quotient estimate) and a final
// register gathers the lanes into the output pixel. The throughput of one item per cycle is
// set by this pipeline, which stalls stage by stage so bubbles fill while the output waits.
// The factor and combine modes come from three configuration registers that reset to zero
// and are to be written only while no item is in flight.
module rgba_blend_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rbu_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [rbu_pkg::CfgDataW-1:0]  cfg_data,
  rbu_pixel_if.sink                     pix,
  rbu_result_if.source                  res
);

  logic [1:0] own_factor_mode;
  logic [1:0] incoming_factor_mode;
  logic [1:0] combine_mode;

  logic [rbu_pkg::ChanW-1:0] own_factor;
  logic [rbu_pkg::ChanW-1:0] inc_factor;

  logic [rbu_pkg::NumChannels-1:0][rbu_pkg::ChanW-1:0] own_chan;
  logic [rbu_pkg::NumChannels-1:0][rbu_pkg::ChanW-1:0] inc_chan;
  logic [rbu_pkg::NumChannels-1:0][rbu_pkg::ChanW-1:0] lane_result;
  logic [rbu_pkg::NumChannels-1:0][rbu_pkg::ChanW-1:0] merged;

  rbu_pkg::rbu_load_t load;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_factor_mode      <= rbu_pkg::FactorOne;
      incoming_factor_mode <= rbu_pkg::FactorOne;
      combine_mode         <= rbu_pkg::CombineKeep;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbu_pkg::RegOwnFactor: own_factor_mode      <= cfg_data;
        rbu_pkg::RegIncFactor: incoming_factor_mode <= cfg_data;
        rbu_pkg::RegCombine:   combine_mode         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the two factors from own alpha
  assign own_factor = rbu_pkg::pick_factor(own_factor_mode, pix.own_alpha);
  assign inc_factor = rbu_pkg::pick_factor(incoming_factor_mode, pix.own_alpha);

  // Spread the channels over the lanes
  assign own_chan = {pix.own_alpha, pix.own_blue, pix.own_green, pix.own_red};
  assign inc_chan = {pix.incoming_alpha, pix.incoming_blue, pix.incoming_green,
                     pix.incoming_red};

  rbu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .out_ready (res.ready),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .load      (load)
  );

  for (genvar ch = 0; ch < rbu_pkg::NumChannels; ch++) begin : g_lane
    rbu_lane u_lane (
      .clk          (clk),
      .own_chan     (own_chan[ch]),
      .inc_chan     (inc_chan[ch]),
      .own_factor   (own_factor),
      .inc_factor   (inc_factor),
      .combine_mode (combine_mode),
      .load         (load),
      .result       (lane_result[ch])
    );
  end

  rbu_merge u_merge (
    .clk         (clk),
    .load        (load),
    .lane_result (lane_result),
    .merged      (merged)
  );

  assign res.out_red   = merged[0];
  assign res.out_green = merged[1];
  assign res.out_blue  = merged[2];
  assign res.out_alpha = merged[3];

endmodule

[rtl/rbu_checker.sv]
`timescale 1ns / 1ps

module rbu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);

  // A stalled result keeps its valid and its pixel
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_red, out_green, out_blue, out_alpha}))
    else $error("stalled result changed");

  // Reset empties the pipeline
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // An empty output register never blocks the input
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // With the output side ready throughout, an accepted item comes out of the pipeline
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("item lost or late in pipeline");

endmodule

bind rgba_blend_unit rbu_checker u_rbu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix.valid),
  .in_ready  (pix.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_red   (res.out_red),
  .out_green (res.out_green),
  .out_blue  (res.out_blue),
  .out_alpha (res.out_alpha)
);
